// ----- sv/grb_pkg.sv -----
package grb_pkg;

	// Width of the value field on both streams.
	localparam int unsigned WORD_BITS = 32;

	// Width of the group size register.
	localparam int unsigned GSIZE_BITS = 7;

	// Sequencer states.
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_DRAIN
	} grb_state_t;

	// One result word with its markers, as it sits in the output queue.
	typedef struct packed {
		logic [WORD_BITS-1:0] value;
		logic                 burst_last;
		logic                 list_done;
	} grb_word_t;

	// Markers that travel beside a buffer read until its data returns.
	typedef struct packed {
		logic burst_last;
		logic list_done;
	} grb_tag_t;

endpackage

// ----- sv/grb_ram.sv -----
module grb_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/grb_out_fifo.sv -----
module grb_out_fifo
	import grb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  grb_word_t  push_word,
	input  logic       pop,
	output logic       not_empty,
	output grb_word_t  head_word,
	output logic [1:0] count
);

	grb_word_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign not_empty = (cnt_q != 2'd0);
	assign head_word = slot_q[rd_ptr_q];
	assign count     = cnt_q;

	// Storage for the two queued words.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- sv/group_reversal_buffer_unit.sv -----
// Group reversal buffer.
// Input words arrive on s_tvalid/s_tready/s_tdata, with s_tlast marking the
// final element of a list. Each value is written into a group buffer. When the
// buffer holds group_size values, they leave on the m_ side newest first;
// when a list ends with a partial group, the buffered values leave in their
// original order. m_tlast marks the last word of each burst, and m_tuser marks
// the last word of the whole list. group_size is loaded through cfg_we and
// cfg_wdata; zero acts as one and values above MAX_GROUP act as MAX_GROUP.
// A word that completes no burst leaves s_tready high. A word that starts a
// burst of n results holds s_tready low while the burst is read out of the
// buffer one entry per cycle whenever the output queue has room. The first
// result of a burst passes the drain state, the registered buffer read and
// the output queue before it is valid. A two-entry queue lets the next list
// element be accepted while results still wait. If the receiver stalls, the
// buffer reads pause once the queue is full and resume without loss.
// Reset clears the fill count, the queue and the sequencer and sets
// group_size to one; the buffer contents need no clearing.
module group_reversal_buffer_unit
	import grb_pkg::*;
#(
	parameter int unsigned MAX_GROUP  = 64,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [GSIZE_BITS-1:0] cfg_wdata,  // group_size
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [WORD_BITS-1:0]  s_tdata,    // item_value
	input  logic                  s_tlast,    // list_end
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [WORD_BITS-1:0]  m_tdata,    // out_value
	output logic                  m_tlast,    // burst_last
	output logic                  m_tuser     // list_done
);

	localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int unsigned CW = $clog2(MAX_GROUP + 1);
	localparam int unsigned EW = (CW > GSIZE_BITS) ? CW : GSIZE_BITS;

	grb_state_t            state_q, state_d;
	logic [GSIZE_BITS-1:0] group_size_q;
	logic [AW-1:0]         fill_q, fill_d;
	logic [AW-1:0]         addr_q, addr_d;
	logic [CW-1:0]         left_q, left_d;
	logic                  reverse_q, reverse_d;
	logic                  list_q, list_d;

	logic                  in_accept;
	logic [CW-1:0]         fill_n;
	logic                  group_full;
	logic                  emit;

	logic                  rd_issue;
	logic                  rd_valid_s1;
	grb_tag_t              rd_tag_s1;
	grb_tag_t              issue_tag;
	logic [VALUE_BITS-1:0] wr_data;
	logic [VALUE_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0]  rd_value;

	logic                  q_pop;
	logic [1:0]            q_count;
	logic [2:0]            q_used;
	logic                  q_room;
	grb_word_t             q_push_word;
	grb_word_t             q_head;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GSIZE_BITS'(1);
		end else if (cfg_we) begin
			group_size_q <= cfg_wdata;
		end
	end

	// Value width adaptation on the way in and out of the buffer.
	generate
		if (VALUE_BITS <= WORD_BITS) begin : g_narrow_in
			assign wr_data = s_tdata[VALUE_BITS-1:0];
		end else begin : g_wide_in
			assign wr_data = {{(VALUE_BITS - WORD_BITS){1'b0}}, s_tdata};
		end
		if (VALUE_BITS >= WORD_BITS) begin : g_wide_out
			assign rd_value = rd_data[WORD_BITS-1:0];
		end else begin : g_narrow_out
			assign rd_value = {{(WORD_BITS - VALUE_BITS){1'b0}}, rd_data};
		end
	endgenerate

	// Group completion test: the count reaches the size, with zero acting as
	// one and an oversize setting capped at the buffer depth.
	assign in_accept  = s_tvalid && s_tready;
	assign fill_n     = CW'(fill_q) + CW'(1);
	assign group_full = (EW'(fill_n) >= EW'(group_size_q)) || (fill_n == CW'(MAX_GROUP));
	assign emit       = group_full || s_tlast;

	// Room in the output queue for one more read, counting the read in flight.
	assign q_pop  = m_tvalid && m_tready;
	assign q_used = {1'b0, q_count} + {2'b00, rd_valid_s1};
	assign q_room = (q_used < 3'd2) || (q_pop && (q_used < 3'd3));

	// Sequencer: accept and write in idle, read the burst out in drain.
	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		addr_d    = addr_q;
		left_d    = left_q;
		reverse_d = reverse_q;
		list_d    = list_q;
		s_tready  = 1'b0;
		rd_issue  = 1'b0;
		issue_tag = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_accept) begin
					if (emit) begin
						state_d   = ST_DRAIN;
						fill_d    = '0;
						left_d    = fill_n;
						reverse_d = group_full;
						list_d    = s_tlast;
						addr_d    = group_full ? fill_q : '0;
					end else begin
						fill_d = AW'(fill_n);
					end
				end
			end
			ST_DRAIN: begin
				if (q_room) begin
					rd_issue             = 1'b1;
					issue_tag.burst_last = (left_q == CW'(1));
					issue_tag.list_done  = (left_q == CW'(1)) && list_q;
					left_d               = left_q - CW'(1);
					addr_d               = reverse_q ? (addr_q - AW'(1)) : (addr_q + AW'(1));
					if (left_q == CW'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			left_q    <= '0;
			addr_q    <= '0;
			reverse_q <= 1'b0;
			list_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			fill_q    <= fill_d;
			left_q    <= left_d;
			addr_q    <= addr_d;
			reverse_q <= reverse_d;
			list_q    <= list_d;
		end
	end

	// Read pipeline: markers are registered beside the read so they arrive with its data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_tag_s1 <= issue_tag;
		end
	end

	// Group buffer.
	grb_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (MAX_GROUP)
	) u_store (
		.clk   (clk),
		.we    (in_accept),
		.waddr (fill_q),
		.wdata (wr_data),
		.re    (rd_issue),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	// Output queue.
	assign q_push_word.value      = rd_value;
	assign q_push_word.burst_last = rd_tag_s1.burst_last;
	assign q_push_word.list_done  = rd_tag_s1.list_done;

	grb_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rd_valid_s1),
		.push_word (q_push_word),
		.pop       (q_pop),
		.not_empty (m_tvalid),
		.head_word (q_head),
		.count     (q_count)
	);

	assign m_tdata = q_head.value;
	assign m_tlast = q_head.burst_last;
	assign m_tuser = q_head.list_done;

	// The output queue never takes a word it has no room for.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> ((q_count != 2'd2) || q_pop))
		else $error("output queue overflow");

	// A drain never runs with nothing left to read.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (left_q != '0))
		else $error("drain with empty count");

	// The end-of-list marker only sits on the last word of a burst.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("list end without burst end");

	// A burst always starts from an empty group on the next element.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && emit) |=> (fill_q == '0))
		else $error("fill count not cleared after burst");

endmodule
